// ----- rtl/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants and types for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DIV_W     = 32 + FRAC_BITS;

   localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_FROM_INT = 4'd4,
      OP_TO_INT   = 4'd5,
      OP_INC      = 4'd6,
      OP_DEC      = 4'd7,
      OP_MIN      = 4'd8,
      OP_MAX      = 4'd9
   } op_type;

   typedef struct packed {
      logic [31:0] res;
      logic        lt;
      logic        eq;
      logic        gt;
      logic        dz;
      logic        is_div;
      logic        neg;
   } side_type;

endpackage

// ----- rtl/fpa_divider.sv -----
// ----------------------------------------------------------------------------
// fpa_divider
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpa_divider
   import fpa_pkg::*;
(
   input  logic             clock,
   input  logic             enable,
   input  logic [DIV_W-1:0] dividend,
   input  logic [31:0]      divisor,
   output logic [31:0]      quotient
);

   logic [31:0]      rem_ff [DIV_W];
   logic [DIV_W-1:0] dq_ff  [DIV_W];
   logic [31:0]      d_ff   [DIV_W];

   genvar j;
   generate
      for (j = 0; j < DIV_W; j++) begin : g_stage
         logic [31:0]      rem_src;
         logic [DIV_W-1:0] dq_src;
         logic [31:0]      d_src;
         logic [32:0]      t;
         logic [33:0]      diff;
         logic             ge;
         logic [31:0]      rem_in;
         logic [DIV_W-1:0] dq_in;

         if (j == 0) begin : g_first
            assign rem_src = '0;
            assign dq_src  = dividend;
            assign d_src   = divisor;
         end else begin : g_next
            assign rem_src = rem_ff[j-1];
            assign dq_src  = dq_ff[j-1];
            assign d_src   = d_ff[j-1];
         end

         always_comb begin
            t      = {rem_src, dq_src[DIV_W-1]};
            diff   = {1'b0, t} - {2'b00, d_src};
            ge     = ~diff[33];
            rem_in = ge ? diff[31:0] : t[31:0];
            dq_in  = {dq_src[DIV_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[j] <= rem_in;
               dq_ff[j]  <= dq_in;
               d_ff[j]   <= d_src;
            end
         end
      end
   endgenerate

   assign quotient = dq_ff[DIV_W-1][31:0];

endmodule

// ----- rtl/fixed_point_alu_top.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu_top
// Q(32-FRAC_BITS).FRAC_BITS signed fixed-point ALU, fully pipelined.
// ----------------------------------------------------------------------------
// One item enters per cycle while no result waits, and each item gives one
// result; all opcodes pass the input and decode registers, the divider
// pipeline that resolves one quotient bit per stage over 32 + FRAC_BITS
// stages, and the output register. The whole pipeline holds while a result
// waits; req_ready is high whenever the output register is empty or taken.
module fixed_point_alu_top
   import fpa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_op,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result,
   output logic               rsp_a_less_b,
   output logic               rsp_a_equal_b,
   output logic               rsp_a_greater_b,
   output logic               rsp_divide_by_zero
);

   logic en;

   logic               p0_v_ff;
   logic [3:0]         p0_op_ff;
   logic signed [31:0] p0_a_ff, p0_b_ff;

   logic               p1_v_ff;
   side_type           p1_side_ff, p1_side_in;
   logic               p1_mul_ff, p1_mul_in;
   logic signed [63:0] p1_prod_ff, p1_prod_in;
   logic [DIV_W-1:0]   p1_dvd_ff, p1_dvd_in;
   logic [31:0]        p1_dvs_ff, p1_dvs_in;

   logic               sd_v_ff [DIV_W];
   side_type           sd_ff   [DIV_W];
   side_type           sd0_in;

   logic               out_v_ff;
   logic [31:0]        out_res_ff, out_res_in;
   logic               out_lt_ff, out_eq_ff, out_gt_ff, out_dz_ff;

   logic [31:0]        quotient;

   assign en        = ~out_v_ff | rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_v_ff <= 1'b0;
      end else if (en) begin
         p0_v_ff <= req_valid;
      end
      if (en) begin
         p0_op_ff <= req_op;
         p0_a_ff  <= req_operand_a;
         p0_b_ff  <= req_operand_b;
      end
   end

   // operand decode, product, simple results
   always_comb begin
      logic               lt, eq, gt;
      logic [31:0]        a_mag, b_mag;
      logic signed [63:0] shifted;
      lt = p0_a_ff < p0_b_ff;
      eq = p0_a_ff == p0_b_ff;
      gt = p0_a_ff > p0_b_ff;
      a_mag = p0_a_ff[31] ? 32'(-p0_a_ff) : 32'(p0_a_ff);
      b_mag = p0_b_ff[31] ? 32'(-p0_b_ff) : 32'(p0_b_ff);
      shifted = 64'(p0_a_ff) <<< FRAC_BITS;

      p1_side_in        = '0;
      p1_side_in.lt     = lt;
      p1_side_in.eq     = eq;
      p1_side_in.gt     = gt;
      p1_side_in.neg    = p0_a_ff[31] ^ p0_b_ff[31];
      p1_mul_in         = 1'b0;
      p1_prod_in        = 64'(p0_a_ff) * 64'(p0_b_ff);
      p1_dvd_in         = {a_mag, {FRAC_BITS{1'b0}}};
      p1_dvs_in         = b_mag;

      unique case (p0_op_ff)
         OP_ADD: p1_side_in.res = p0_a_ff + p0_b_ff;
         OP_SUB: p1_side_in.res = p0_a_ff - p0_b_ff;
         OP_MUL: p1_mul_in = 1'b1;
         OP_DIV: begin
            if (p0_b_ff == 32'sd0) begin
               p1_side_in.dz = 1'b1;
            end else begin
               p1_side_in.is_div = 1'b1;
            end
         end
         OP_FROM_INT: begin
            if (shifted[63:31] != {33{shifted[31]}}) begin
               p1_side_in.res = p0_a_ff[31] ? INT_MIN : INT_MAX;
            end else begin
               p1_side_in.res = shifted[31:0];
            end
         end
         OP_TO_INT: p1_side_in.res = 32'(p0_a_ff >>> FRAC_BITS);
         OP_INC:    p1_side_in.res = p0_a_ff + 32'sd1;
         OP_DEC:    p1_side_in.res = p0_a_ff - 32'sd1;
         OP_MIN:    p1_side_in.res = lt ? p0_a_ff : p0_b_ff;
         OP_MAX:    p1_side_in.res = gt ? p0_a_ff : p0_b_ff;
         default:   p1_side_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (en) begin
         p1_v_ff <= p0_v_ff;
      end
      if (en) begin
         p1_side_ff <= p1_side_in;
         p1_mul_ff  <= p1_mul_in;
         p1_prod_ff <= p1_prod_in;
         p1_dvd_ff  <= p1_dvd_in;
         p1_dvs_ff  <= p1_dvs_in;
      end
   end

   always_comb begin
      logic signed [63:0] prod_sh;
      prod_sh = p1_prod_ff >>> FRAC_BITS;
      sd0_in  = p1_side_ff;
      if (p1_mul_ff) begin
         sd0_in.res = prod_sh[31:0];
      end
   end

   fpa_divider u_divider (
      .clock    (clock),
      .enable   (en),
      .dividend (p1_dvd_ff),
      .divisor  (p1_dvs_ff),
      .quotient (quotient)
   );

   // side data travels alongside the divider stages
   genvar k;
   generate
      for (k = 0; k < DIV_W; k++) begin : g_side
         always_ff @(posedge clock) begin
            if (reset) begin
               sd_v_ff[k] <= 1'b0;
            end else if (en) begin
               sd_v_ff[k] <= (k == 0) ? p1_v_ff : sd_v_ff[(k == 0) ? 0 : k-1];
            end
            if (en) begin
               sd_ff[k] <= (k == 0) ? sd0_in : sd_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   endgenerate

   always_comb begin
      side_type s;
      s = sd_ff[DIV_W-1];
      if (s.is_div) begin
         out_res_in = s.neg ? 32'(-quotient) : quotient;
      end else begin
         out_res_in = s.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= sd_v_ff[DIV_W-1];
      end
      if (en) begin
         out_res_ff <= out_res_in;
         out_lt_ff  <= sd_ff[DIV_W-1].lt;
         out_eq_ff  <= sd_ff[DIV_W-1].eq;
         out_gt_ff  <= sd_ff[DIV_W-1].gt;
         out_dz_ff  <= sd_ff[DIV_W-1].dz;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_result         = out_res_ff;
   assign rsp_a_less_b       = out_lt_ff;
   assign rsp_a_equal_b      = out_eq_ff;
   assign rsp_a_greater_b    = out_gt_ff;
   assign rsp_divide_by_zero = out_dz_ff;

   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_a_less_b, rsp_a_equal_b, rsp_a_greater_b}))
      else $error("comparison flags not exclusive");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_result == 32'sd0)
      else $error("divide by zero with nonzero result");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while pipeline stalled");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
      else $error("stalled result changed");

endmodule

// ----- tb/fixed_point_alu_checker.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu_checker
// Watches the request and response channels of the fixed-point ALU, computes
// the expected result of every accepted request and compares each accepted
// response against the oldest pending expectation, field by field.
// ----------------------------------------------------------------------------
module fixed_point_alu_checker
   import fpa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [3:0]         req_op,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_result,
   input  logic               rsp_a_less_b,
   input  logic               rsp_a_equal_b,
   input  logic               rsp_a_greater_b,
   input  logic               rsp_divide_by_zero,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic [31:0] result;
      logic        lt;
      logic        eq;
      logic        gt;
      logic        dz;
   } alu_out_type;

   alu_out_type expected_q[$];

   function automatic alu_out_type alu_predict(logic [3:0] op, logic signed [31:0] a,
                                               logic signed [31:0] b);
      alu_out_type o;
      logic signed [63:0] wa, wb, prod, dividend;
      wa = a;
      wb = b;
      o = '0;
      o.lt = a < b;
      o.eq = a == b;
      o.gt = a > b;
      case (op)
         OP_ADD: o.result = a + b;
         OP_SUB: o.result = a - b;
         OP_MUL: begin
            prod = (wa * wb) >>> FRAC_BITS;
            o.result = prod[31:0];
         end
         OP_DIV: begin
            if (b == 0) begin
               o.dz = 1'b1;
            end else begin
               dividend = wa <<< FRAC_BITS;
               prod = dividend / wb;
               o.result = prod[31:0];
            end
         end
         OP_FROM_INT: begin
            prod = wa <<< FRAC_BITS;
            if (prod > 64'sd2147483647 || prod < -64'sd2147483648)
               o.result = (a > 0) ? INT_MAX : INT_MIN;
            else
               o.result = prod[31:0];
         end
         OP_TO_INT: o.result = a >>> FRAC_BITS;
         OP_INC:    o.result = a + 1;
         OP_DEC:    o.result = a - 1;
         OP_MIN:    o.result = (a < b) ? a : b;
         OP_MAX:    o.result = (a > b) ? a : b;
         default:   o.result = '0;
      endcase
      return o;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      alu_out_type want, got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_q.push_back(alu_predict(req_op, req_operand_a, req_operand_b));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_result, rsp_a_less_b, rsp_a_equal_b, rsp_a_greater_b,
                   rsp_divide_by_zero};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected transfer, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (want != got) begin
                  $display("%0t: mismatch expected res=%h lt=%b eq=%b gt=%b dz=%b",
                           $time, want.result, want.lt, want.eq, want.gt, want.dz);
                  $display("%0t:          actual   res=%h lt=%b eq=%b gt=%b dz=%b",
                           $time, got.result, got.lt, got.eq, got.gt, got.dz);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- tb/fixed_point_alu_top_test.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu_top_test
// Drives directed and random ALU requests through phases of sender and
// receiver idling; the checker predicts and compares every transfer.
// ----------------------------------------------------------------------------
module fixed_point_alu_top_test;
   import fpa_pkg::*;

   localparam int LATENCY   = 35 + FRAC_BITS;
   localparam int CYCLE_MAX = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [3:0]         req_op = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_result;
   logic               rsp_a_less_b, rsp_a_equal_b, rsp_a_greater_b, rsp_divide_by_zero;
   int                 fail_count, pending;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fixed_point_alu_top DUT (.*);

   fixed_point_alu_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_MAX) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);

   function automatic logic signed [31:0] pick_operand();
      case ($urandom_range(7))
         0: return INT_MAX;
         1: return INT_MIN;
         2: return 32'(signed'($urandom_range(16)) - 8);
         3: return 32'(signed'($urandom_range(8192)) - 4096);
         4: return 32'($urandom_range(3)) << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // valid stays high into the next item unless an idle cycle is chosen
   task automatic send_item(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_random(int count);
      logic signed [31:0] a;
      for (int i = 0; i < count; i++) begin
         a = pick_operand();
         send_item(4'($urandom_range(15)), a,
                   ($urandom_range(5) == 0) ? a : pick_operand());
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int op = 0; op < 16; op++)
         send_item(4'(op), 32'sd1000, -32'sd300);
      send_item(OP_DIV, 32'sd5, 32'sd0);
      send_item(OP_DIV, INT_MIN, -32'sd1);
      send_item(OP_MUL, INT_MIN, INT_MIN);
      send_item(OP_FROM_INT, 32'sd8388608, 32'sd0);
      send_item(OP_FROM_INT, -32'sd8388609, 32'sd0);
      send_item(OP_INC, INT_MAX, INT_MAX);
      send_item(OP_DEC, INT_MIN, INT_MIN);
      send_item(OP_TO_INT, -32'sd1, 32'sd1);
      send_item(OP_MIN, 32'sd7, 32'sd7);
      req_valid <= 1'b0;

      while (pending != 0)
         @(negedge clock);

      send_random(100);
      send_idle_pct = 82;
      send_random(100);
      send_idle_pct = 0;
      recv_stall_pct = 82;
      send_random(100);
      send_idle_pct = 34;
      recv_stall_pct = 34;
      send_random(100);
      req_valid <= 1'b0;
      recv_stall_pct = 0;

      while (pending != 0)
         @(negedge clock);
      repeat (2 * LATENCY) @(negedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
